@@ hdl/socd_pkg.sv @@
// ----------------------------------------------------------------------------
// socd_pkg
// Shared types, register map and helpers of the last-input SOCD resolver.
// ----------------------------------------------------------------------------
package socd_pkg;

    // apb register map
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int RUN_LEN  = 3;

    typedef enum logic [2:0] {
        REG_CODE_RIGHT   = 3'd0,
        REG_CODE_LEFT    = 3'd1,
        REG_CODE_FORWARD = 3'd2,
        REG_CODE_BACK    = 3'd3,
        REG_AUTO_STOP    = 3'd4,
        REG_STOP_PAUSE   = 3'd5
    } t_reg_idx;

    // register reset values
    localparam logic [7:0]  RST_CODE_RIGHT   = 8'h44;
    localparam logic [7:0]  RST_CODE_LEFT    = 8'h41;
    localparam logic [7:0]  RST_CODE_FORWARD = 8'h57;
    localparam logic [7:0]  RST_CODE_BACK    = 8'h53;
    localparam logic        RST_AUTO_STOP    = 1'b0;
    localparam logic [15:0] RST_STOP_PAUSE   = 16'd60;

    // key slot numbers, opposite pairs differ in bit 0
    localparam logic [1:0] KEY_RIGHT   = 2'd0;
    localparam logic [1:0] KEY_LEFT    = 2'd1;
    localparam logic [1:0] KEY_FORWARD = 2'd2;
    localparam logic [1:0] KEY_BACK    = 2'd3;

    typedef struct packed {
        logic [7:0]  code_right;
        logic [7:0]  code_left;
        logic [7:0]  code_forward;
        logic [7:0]  code_back;
        logic        auto_stop_on;
        logic [15:0] stop_pause_ms;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  code;
        logic        rel;
        logic [15:0] pause;
        logic        burst;
        logic        last;
    } t_result;

    // one input's run of synthetic events, entry 0 goes out first
    typedef struct packed {
        logic [1:0]                cnt;
        t_result [RUN_LEN-1:0]     res;
    } t_run;

    function automatic t_result mk_result(input logic [7:0] code, input logic rel,
                                          input logic [15:0] pause, input logic burst,
                                          input logic last);
        t_result r;
        r.code  = code;
        r.rel   = rel;
        r.pause = pause;
        r.burst = burst;
        r.last  = last;
        return r;
    endfunction

endpackage

@@ hdl/socd_if.sv @@
// ----------------------------------------------------------------------------
// socd_if
// Valid/ready channels for key events in and synthetic events out.
// ----------------------------------------------------------------------------
interface socd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       is_release;
    logic       skip_item;

    modport source (output valid, output key_code, output is_release,
                    output skip_item, input ready);
    modport sink   (input valid, input key_code, input is_release,
                    input skip_item, output ready);
endinterface

interface socd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_code;
    logic        out_release;
    logic [15:0] pause_after_ms;
    logic        burst_event;
    logic        last_of_run;

    modport source (output valid, output out_code, output out_release,
                    output pause_after_ms, output burst_event,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_code, input out_release,
                    input pause_after_ms, input burst_event,
                    input last_of_run, output ready);
endinterface

@@ hdl/socd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// socd_cfg_regs
// APB register file holding key codes and auto-stop settings.
// ----------------------------------------------------------------------------
module socd_cfg_regs
    import socd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_right    <= RST_CODE_RIGHT;
            r_cfg.code_left     <= RST_CODE_LEFT;
            r_cfg.code_forward  <= RST_CODE_FORWARD;
            r_cfg.code_back     <= RST_CODE_BACK;
            r_cfg.auto_stop_on  <= RST_AUTO_STOP;
            r_cfg.stop_pause_ms <= RST_STOP_PAUSE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CODE_RIGHT:   r_cfg.code_right    <= pwdata[7:0];
                REG_CODE_LEFT:    r_cfg.code_left     <= pwdata[7:0];
                REG_CODE_FORWARD: r_cfg.code_forward  <= pwdata[7:0];
                REG_CODE_BACK:    r_cfg.code_back     <= pwdata[7:0];
                REG_AUTO_STOP:    r_cfg.auto_stop_on  <= pwdata[0];
                REG_STOP_PAUSE:   r_cfg.stop_pause_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_CODE_RIGHT:   prdata = {{(DATA_W-8){1'b0}}, r_cfg.code_right};
            REG_CODE_LEFT:    prdata = {{(DATA_W-8){1'b0}}, r_cfg.code_left};
            REG_CODE_FORWARD: prdata = {{(DATA_W-8){1'b0}}, r_cfg.code_forward};
            REG_CODE_BACK:    prdata = {{(DATA_W-8){1'b0}}, r_cfg.code_back};
            REG_AUTO_STOP:    prdata = {{(DATA_W-1){1'b0}}, r_cfg.auto_stop_on};
            REG_STOP_PAUSE:   prdata = {{(DATA_W-16){1'b0}}, r_cfg.stop_pause_ms};
            default:          prdata = '0;
        endcase
    end

endmodule

@@ hdl/socd_resolve.sv @@
// ----------------------------------------------------------------------------
// socd_resolve
// Input register, key decode, held/self-release state and run building.
// ----------------------------------------------------------------------------
module socd_resolve
    import socd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    socd_in_if.sink    i_in,
    input  t_cfg       i_cfg,
    output t_run       o_run,
    output logic       o_run_valid,
    input  logic       i_run_ready
);

    logic       r_in_valid;
    logic [7:0] r_key;
    logic       r_rel;
    logic       r_skip;
    logic [3:0] r_held;
    logic [3:0] r_self;
    logic [3:0] n_held;
    logic [3:0] n_self;
    logic       advance;
    logic       hit;
    logic [1:0] k;
    logic [1:0] o;
    logic [7:0] codes [4];

    assign advance     = r_in_valid && i_run_ready;
    assign i_in.ready  = !r_in_valid || i_run_ready;
    assign o_run_valid = r_in_valid;

    assign codes[KEY_RIGHT]   = i_cfg.code_right;
    assign codes[KEY_LEFT]    = i_cfg.code_left;
    assign codes[KEY_FORWARD] = i_cfg.code_forward;
    assign codes[KEY_BACK]    = i_cfg.code_back;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_key  <= i_in.key_code;
            r_rel  <= i_in.is_release;
            r_skip <= i_in.skip_item;
        end
    end

    // key decode, first match wins
    always_comb begin
        hit = 1'b1;
        k   = KEY_RIGHT;
        priority if (r_key == i_cfg.code_right)   k = KEY_RIGHT;
        else if (r_key == i_cfg.code_left)        k = KEY_LEFT;
        else if (r_key == i_cfg.code_forward)     k = KEY_FORWARD;
        else if (r_key == i_cfg.code_back)        k = KEY_BACK;
        else                                      hit = 1'b0;
    end

    assign o = k ^ 2'd1;

    // next state and run of synthetic events
    always_comb begin
        n_held = r_held;
        n_self = r_self;
        o_run  = '0;
        if (!r_skip && hit) begin
            if (!r_rel) begin
                // press while opposite held and this key not held releases the opposite
                if (r_held[o] && !r_held[k]) begin
                    n_self[o]    = 1'b1;
                    o_run.res[0] = mk_result(codes[o], 1'b1, 16'd0, 1'b0, 1'b1);
                    o_run.cnt    = 2'd1;
                end
                n_held[k] = 1'b1;
            end else begin
                if (r_self[k]) begin
                    n_self[k] = 1'b0;
                end else begin
                    n_held[k] = 1'b0;
                end
                if (r_held[o]) begin
                    // re-press the opposite
                    o_run.res[0] = mk_result(codes[o], 1'b0, 16'd0, 1'b0, 1'b1);
                    o_run.cnt    = 2'd1;
                end else if (i_cfg.auto_stop_on) begin
                    // counter-tap burst
                    o_run.res[0] = mk_result(codes[k], 1'b1, 16'd0, 1'b1, 1'b0);
                    o_run.res[1] = mk_result(codes[o], 1'b0, i_cfg.stop_pause_ms,
                                             1'b1, 1'b0);
                    o_run.res[2] = mk_result(codes[o], 1'b1, 16'd0, 1'b1, 1'b1);
                    o_run.cnt    = 2'd3;
                end
            end
        end
    end

    // key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_self <= '0;
        end else if (advance) begin
            r_held <= n_held;
            r_self <= n_self;
        end
    end

`ifndef ASSERT_OFF
    // a self-made release is only ever marked on a held key
    a_self_within_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_self & ~r_held) == 4'd0)
        else $error("self-release mark on a key that is not held");

    // a three-event run is always a complete burst
    a_burst_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_run_valid && o_run.cnt == 2'd3) |->
        (o_run.res[0].burst && o_run.res[1].burst && o_run.res[2].burst &&
         o_run.res[2].last && !o_run.res[1].last))
        else $error("malformed counter-tap burst");
`endif

endmodule

@@ hdl/socd_out_seq.sv @@
// ----------------------------------------------------------------------------
// socd_out_seq
// Result register that shifts out a run of synthetic events, one event per transfer.
// ----------------------------------------------------------------------------
module socd_out_seq
    import socd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_run        i_run,
    input  logic        i_run_valid,
    output logic        o_run_ready,
    socd_out_if.source  o_res
);

    logic [1:0]            r_cnt;
    t_result [RUN_LEN-1:0] r_res;
    logic                  take;
    logic                  load;

    assign o_res.valid          = (r_cnt != 2'd0);
    assign take                 = o_res.valid && o_res.ready;
    assign o_run_ready          = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_res.ready);
    assign load                 = i_run_valid && o_run_ready;

    assign o_res.out_code       = r_res[0].code;
    assign o_res.out_release    = r_res[0].rel;
    assign o_res.pause_after_ms = r_res[0].pause;
    assign o_res.burst_event    = r_res[0].burst;
    assign o_res.last_of_run    = r_res[0].last;

    // pending count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= i_run.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // result shift register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_run.res;
        end else if (take) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

`ifndef ASSERT_OFF
    // the head carries the last flag exactly when one event is left
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_res[0].last) |-> (r_cnt == 2'd1))
        else $error("last_of_run shown before the end of the run");

    a_final_has_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_res[0].last)
        else $error("final event of a run lacks last_of_run");
`endif

endmodule

@@ hdl/socd_last_input_resolver_top.sv @@
// ----------------------------------------------------------------------------
// socd_last_input_resolver_top
// Path: an input is registered in socd_resolve; its run is loaded into the result
// shift register of socd_out_seq once that is free, and its head goes out first.
// Throughput: one input per cycle with the receiver ready when it yields zero
// or one result; an input with a counter-tap burst holds the result shift
// register until the last of its three events is transferred.
// Reset: synchronous active low; key state cleared, registers to defaults.
// ----------------------------------------------------------------------------
module socd_last_input_resolver_top
    import socd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    socd_in_if.sink           i_in,
    socd_out_if.source        o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;
    t_run run;
    logic run_valid;
    logic run_ready;

    // configuration registers
    socd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // decode and key state
    socd_resolve u_resolve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .o_run       (run),
        .o_run_valid (run_valid),
        .i_run_ready (run_ready)
    );

    // result sequencing
    socd_out_seq u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (run),
        .i_run_valid (run_valid),
        .o_run_ready (run_ready),
        .o_res       (o_res)
    );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the last-input SOCD resolver: key events go in over
// a valid/ready channel, a local last-input predictor tracks held and
// self-released keys, and every synthetic event that comes out is checked in
// order against it. Registers are set over APB between phases.
// ----------------------------------------------------------------------------
module tb;
    import socd_pkg::*;

    localparam int          LONG_HOLD    = 80;
    localparam int          SETTLE       = 8;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          SHOW_MAX     = 10;
    localparam logic [2:0]  REG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0]  REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [7:0] code;
        logic       rel;
        logic       skip;
    } t_key_evt;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    socd_in_if  key_if ();
    socd_out_if inj_if ();

    socd_last_input_resolver_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_if),
        .o_res   (inj_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and register shadow
    t_cfg       cfg;
    logic [3:0] key_held;
    logic [3:0] key_self_rel;
    t_result    inject_q[$];

    // stimulus bookkeeping
    t_key_evt   typed_q[$];
    int         events_queued;
    int         events_taken;
    int         fail_cnt;
    int         quiet_cycles;
    int         tx_gap;
    int         rx_hold;
    int         stalls_asked;
    int         stalls_served;
    logic       calm;
    logic       in_took;
    logic [3:0] phys_down;

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [7:0] slot_code(input logic [1:0] s);
        case (s)
            KEY_RIGHT:   return cfg.code_right;
            KEY_LEFT:    return cfg.code_left;
            KEY_FORWARD: return cfg.code_forward;
            default:     return cfg.code_back;
        endcase
    endfunction

    function automatic t_result inject_evt(input logic [7:0] code, input logic rel,
                                           input logic [15:0] pause, input logic burst);
        t_result r;
        r.code  = code;
        r.rel   = rel;
        r.pause = pause;
        r.burst = burst;
        r.last  = 1'b0;
        return r;
    endfunction

    // last-input priority: work out the synthetic events one key event causes
    function automatic void resolve_key_event(input t_key_evt ev);
        logic [1:0] k;
        logic [1:0] o;
        t_result    run[$];
        if (ev.skip)
            return;
        if (ev.code == cfg.code_right)
            k = KEY_RIGHT;
        else if (ev.code == cfg.code_left)
            k = KEY_LEFT;
        else if (ev.code == cfg.code_forward)
            k = KEY_FORWARD;
        else if (ev.code == cfg.code_back)
            k = KEY_BACK;
        else
            return;
        o = k ^ 2'b01;
        if (!ev.rel) begin
            // new press beats a held opposite
            if (key_held[o] && !key_held[k]) begin
                key_self_rel[o] = 1'b1;
                run.push_back(inject_evt(slot_code(o), 1'b1, 16'd0, 1'b0));
            end
            key_held[k] = 1'b1;
        end else begin
            // our own release coming back keeps the key held
            if (key_self_rel[k])
                key_self_rel[k] = 1'b0;
            else
                key_held[k] = 1'b0;
            if (key_held[o]) begin
                run.push_back(inject_evt(slot_code(o), 1'b0, 16'd0, 1'b0));
            end else if (cfg.auto_stop_on) begin
                run.push_back(inject_evt(slot_code(k), 1'b1, 16'd0, 1'b1));
                run.push_back(inject_evt(slot_code(o), 1'b0, cfg.stop_pause_ms, 1'b1));
                run.push_back(inject_evt(slot_code(o), 1'b1, 16'd0, 1'b1));
            end
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            inject_q.push_back(run[i]);
    endfunction

    function automatic void push_ev(input logic [7:0] code, input logic rel,
                                    input logic skip);
        t_key_evt ev;
        ev.code = code;
        ev.rel  = rel;
        ev.skip = skip;
        typed_q.push_back(ev);
        events_queued++;
    endfunction

    // a code that none of the key registers holds
    function automatic logic [7:0] stray_code();
        logic [7:0] c;
        do c = 8'($urandom);
        while (c == cfg.code_right || c == cfg.code_left ||
               c == cfg.code_forward || c == cfg.code_back);
        return c;
    endfunction

    // apb write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CODE_RIGHT:   cfg.code_right    = val[7:0];
            REG_CODE_LEFT:    cfg.code_left     = val[7:0];
            REG_CODE_FORWARD: cfg.code_forward  = val[7:0];
            REG_CODE_BACK:    cfg.code_back     = val[7:0];
            REG_AUTO_STOP:    cfg.auto_stop_on  = val[0];
            REG_STOP_PAUSE:   cfg.stop_pause_ms = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] r, input logic [7:0] l,
                               input logic [7:0] f, input logic [7:0] b,
                               input logic auto_on, input logic [15:0] pause);
        write_reg(REG_CODE_RIGHT, {24'd0, r});
        write_reg(REG_CODE_LEFT, {24'd0, l});
        write_reg(REG_CODE_FORWARD, {24'd0, f});
        write_reg(REG_CODE_BACK, {24'd0, b});
        write_reg(REG_AUTO_STOP, {31'd0, auto_on});
        write_reg(REG_STOP_PAUSE, {16'd0, pause});
    endtask

    // random key map, optionally with right and back sharing one code
    task automatic shuffle_keys(input logic dup);
        logic [7:0] r;
        logic [7:0] l;
        logic [7:0] f;
        logic [7:0] b;
        r = 8'($urandom);
        do l = 8'($urandom); while (l == r);
        do f = 8'($urandom); while (f == r || f == l);
        do b = 8'($urandom); while (b == r || b == l || b == f);
        if (dup)
            b = r;
        load_config(r, l, f, b, 1'($urandom_range(0, 1)), 16'($urandom));
    endtask

    // wait for every expectation, then let in-flight work finish
    task automatic wait_idle();
        do @(negedge i_clk);
        while (events_taken != events_queued || inject_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // player-like typing: toggle keys, mostly on one pair, with echoes of
    // injected events coming back, plus stray codes and returned burst events
    task automatic gen_typing(input int n);
        int         made;
        int         pick;
        logic [1:0] s;
        logic [1:0] o;
        logic       pair;
        @(posedge i_clk);
        made = 0;
        pair = 1'($urandom_range(0, 1));
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                push_ev(stray_code(), 1'($urandom_range(0, 1)), 1'b0);
                made++;
            end else if (pick < 12) begin
                push_ev(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
                made++;
            end else begin
                if ($urandom_range(0, 9) < 3)
                    pair = ~pair;
                s = {pair, 1'($urandom_range(0, 1))};
                o = s ^ 2'b01;
                if (pick < 20) begin
                    // repeat of the key's current state, or a stray flip
                    push_ev(slot_code(s), 1'($urandom_range(0, 1)), 1'b0);
                end else begin
                    phys_down[s] = ~phys_down[s];
                    push_ev(slot_code(s), ~phys_down[s], 1'b0);
                    if (phys_down[o] && $urandom_range(0, 9) < 7) begin
                        push_ev(slot_code(o), phys_down[s], 1'b0);
                        made++;
                    end
                end
                made++;
            end
        end
    endtask

    // key event driver
    always @(negedge i_clk) begin : drive_keys
        t_key_evt ev;
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
        end else if (!key_if.valid || in_took) begin
            if (tx_gap > 0) begin
                tx_gap--;
                key_if.valid <= 1'b0;
            end else if (typed_q.size() == 0) begin
                key_if.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(1, 8) - 1;
                key_if.valid <= 1'b0;
            end else begin
                ev = typed_q.pop_front();
                key_if.key_code   <= ev.code;
                key_if.is_release <= ev.rel;
                key_if.skip_item  <= ev.skip;
                key_if.valid      <= 1'b1;
            end
        end
    end

    // result receiver with random and long hold-offs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            inj_if.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            inj_if.ready <= 1'b0;
        end else if (stalls_served != stalls_asked) begin
            stalls_served++;
            rx_hold = LONG_HOLD - 1;
            inj_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(1, 8) - 1;
            inj_if.ready <= 1'b0;
        end else begin
            inj_if.ready <= 1'b1;
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin : watch
        t_key_evt ev;
        t_result  got;
        t_result  want;
        logic     in_xfer;
        logic     out_xfer;
        in_xfer  = i_rst_n && key_if.valid && key_if.ready;
        out_xfer = i_rst_n && inj_if.valid && inj_if.ready;
        in_took <= in_xfer;
        if (out_xfer) begin
            got.code  = inj_if.out_code;
            got.rel   = inj_if.out_release;
            got.pause = inj_if.pause_after_ms;
            got.burst = inj_if.burst_event;
            got.last  = inj_if.last_of_run;
            if (inject_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= SHOW_MAX)
                    $display("unexpected transfer: code=%02h rel=%b pause=%0d burst=%b last=%b",
                             got.code, got.rel, got.pause, got.burst, got.last);
            end else begin
                want = inject_q.pop_front();
                if (got.code !== want.code || got.rel !== want.rel ||
                    got.pause !== want.pause || got.burst !== want.burst ||
                    got.last !== want.last) begin
                    fail_cnt++;
                    if (fail_cnt <= SHOW_MAX) begin
                        $write("mismatch: want code=%02h rel=%b pause=%0d burst=%b last=%b",
                               want.code, want.rel, want.pause, want.burst, want.last);
                        $display(" got code=%02h rel=%b pause=%0d burst=%b last=%b",
                                 got.code, got.rel, got.pause, got.burst, got.last);
                    end
                end
            end
        end
        if (in_xfer) begin
            ev.code = key_if.key_code;
            ev.rel  = key_if.is_release;
            ev.skip = key_if.skip_item;
            resolve_key_event(ev);
            events_taken++;
        end
        // watchdog on cycles without any transfer
        if (in_xfer || out_xfer || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // sequence of phases
    initial begin
        int base;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        key_if.valid      = 1'b0;
        key_if.key_code   = 8'd0;
        key_if.is_release = 1'b0;
        key_if.skip_item  = 1'b0;
        inj_if.ready      = 1'b0;
        cfg.code_right    = RST_CODE_RIGHT;
        cfg.code_left     = RST_CODE_LEFT;
        cfg.code_forward  = RST_CODE_FORWARD;
        cfg.code_back     = RST_CODE_BACK;
        cfg.auto_stop_on  = RST_AUTO_STOP;
        cfg.stop_pause_ms = RST_STOP_PAUSE;
        key_held          = '0;
        key_self_rel      = '0;
        phys_down         = '0;
        events_queued     = 0;
        events_taken      = 0;
        fail_cnt          = 0;
        quiet_cycles      = 0;
        tx_gap            = 0;
        rx_hold           = 0;
        stalls_asked      = 0;
        stalls_served     = 0;
        calm              = 1'b0;
        in_took           = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(negedge i_clk);

        // reset key map, auto-stop off
        @(posedge i_clk);
        push_ev(RST_CODE_RIGHT, 1'b0, 1'b0);
        push_ev(RST_CODE_RIGHT, 1'b0, 1'b0);     // already held
        push_ev(RST_CODE_LEFT, 1'b0, 1'b0);      // kicks right out
        push_ev(RST_CODE_LEFT, 1'b1, 1'b0);      // right comes back
        push_ev(RST_CODE_RIGHT, 1'b1, 1'b0);     // our own release echoed
        push_ev(RST_CODE_RIGHT, 1'b1, 1'b0);     // real release, no burst
        push_ev(RST_CODE_FORWARD, 1'b0, 1'b0);
        push_ev(RST_CODE_BACK, 1'b0, 1'b0);
        push_ev(RST_CODE_FORWARD, 1'b1, 1'b0);
        push_ev(RST_CODE_BACK, 1'b1, 1'b0);
        push_ev(RST_CODE_FORWARD, 1'b1, 1'b0);
        push_ev(8'h00, 1'b0, 1'b0);              // unknown key
        push_ev(RST_CODE_RIGHT, 1'b0, 1'b1);     // returned burst event
        wait_idle();

        // extreme codes and pause, auto-stop on, unmapped writes ignored
        load_config(8'h00, 8'hff, 8'haa, 8'h55, 1'b1, 16'hffff);
        write_reg(REG_UNMAPPED_LO, 32'hffff_ffff);
        write_reg(REG_UNMAPPED_HI, 32'hffff_ffff);
        @(posedge i_clk);
        push_ev(8'h00, 1'b0, 1'b0);
        push_ev(8'h00, 1'b1, 1'b0);              // burst
        push_ev(8'h00, 1'b1, 1'b1);
        push_ev(8'hff, 1'b0, 1'b1);
        push_ev(8'haa, 1'b0, 1'b0);
        push_ev(8'haa, 1'b1, 1'b0);
        push_ev(8'hff, 1'b0, 1'b0);
        push_ev(8'h00, 1'b0, 1'b0);
        push_ev(8'h00, 1'b1, 1'b0);
        push_ev(8'hff, 1'b1, 1'b0);              // self-made release, then burst
        push_ev(8'hff, 1'b1, 1'b0);
        wait_idle();

        // shared codes: right wins over back, left wins over forward
        write_reg(REG_CODE_BACK, 32'h0000_0000);
        write_reg(REG_CODE_FORWARD, 32'h0000_00ff);
        write_reg(REG_STOP_PAUSE, 32'h0000_0000);
        @(posedge i_clk);
        push_ev(8'h00, 1'b0, 1'b0);
        push_ev(8'h00, 1'b1, 1'b0);
        wait_idle();

        // random maps and typing
        shuffle_keys(1'b0);
        gen_typing(85);
        wait_idle();

        shuffle_keys(1'b1);
        write_reg(REG_STOP_PAUSE, 32'h0000_ffff);
        base = events_taken;
        gen_typing(85);
        while (events_taken < base + 10)
            @(posedge i_clk);
        stalls_asked++;
        wait_idle();

        shuffle_keys(1'b0);
        gen_typing(85);
        wait_idle();

        // last stretch without idling
        load_config(RST_CODE_RIGHT, RST_CODE_LEFT, RST_CODE_FORWARD, RST_CODE_BACK,
                    1'b1, RST_STOP_PAUSE);
        calm = 1'b1;
        gen_typing(75);
        wait_idle();
        repeat (20) @(posedge i_clk);

        if (fail_cnt == 0 && inject_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
